@@ rtl/core/trpm_pkg.sv @@
`timescale 1ns / 1ps

package trpm_pkg;

  // Field and state widths.
  localparam int RPM_BITS   = 20;
  localparam int COUNT_BITS = 16;
  localparam int CFG_W      = 16;
  localparam int TIME_W     = 32;
  localparam int MPM_W      = 16;

  localparam logic [MPM_W-1:0] MS_PER_MIN = 16'd60000;

  // Datapath widths derived from the field widths.
  localparam int FRESH_W = COUNT_BITS + MPM_W;
  localparam int PROD_W  = RPM_BITS + CFG_W;
  localparam int SUM_W   = ((PROD_W > FRESH_W) ? PROD_W : FRESH_W) + 1;
  localparam int DVD_W   = SUM_W;
  localparam int DIV_W   = TIME_W;
  localparam int DCNT_W  = $clog2(DVD_W + 1);
  localparam int CMP_W   = (RPM_BITS > CFG_W) ? RPM_BITS : CFG_W;
  localparam int SPK_W   = RPM_BITS + 4;
  localparam int OUT_TDATA_W = ((RPM_BITS + 7) / 8) * 8;

  // Spike rule ratio bounds: 7*new < 10*old < 13*new.
  localparam int SPK_LO_MUL  = 7;
  localparam int SPK_MID_MUL = 10;
  localparam int SPK_HI_MUL  = 13;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SPIKE_THR = 1'b1;

  localparam logic [CFG_W-1:0] SPIKE_THR_RST = 16'd20;

  // Input item kinds.
  localparam logic CMD_PULSE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  typedef enum logic [3:0] {
    DOP_NONE,
    DOP_PULSE,
    DOP_EVAL,
    DOP_ZERO,
    DOP_DIV_TAU,
    DOP_TAU_SAVE,
    DOP_DIV_FRESH,
    DOP_FRESH_SAVE,
    DOP_DIV_SUM,
    DOP_SAT,
    DOP_SPK_DIFF,
    DOP_SPK_CMP,
    DOP_EMIT
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TAU,
    ST_TAU_W,
    ST_FDIV,
    ST_FDIV_W,
    ST_SDIV,
    ST_SDIV_W,
    ST_SPK_D,
    ST_SPK_C,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic delta_zero;
    logic div_done;
    logic out_free;
  } dp_sts_t;

endpackage

@@ rtl/core/trpm_div.sv @@
`timescale 1ns / 1ps

module trpm_div
  import trpm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DVD_W-1:0]  dividend,
  input  logic [DIV_W-1:0]  divisor,
  input  logic [DCNT_W-1:0] nbits,
  output logic [DVD_W-1:0]  quotient,
  output logic              done
);

  logic [DCNT_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DVD_W-1:0]  q_r;
  logic [DIV_W-1:0]  rem_r;
  logic [DIV_W-1:0]  dsr_r;
  logic [DCNT_W-1:0] shift_amt;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;

  // The dividend is left aligned so that only nbits steps are needed.
  assign shift_amt = DCNT_W'(DVD_W) - nbits;
  assign trial     = {rem_r, q_r[DVD_W-1]};
  assign diff      = trial - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= nbits;
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      cnt_r <= cnt_r - DCNT_W'(1);
      if (cnt_r == DCNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend << shift_amt;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      if (!diff[DIV_W]) begin
        rem_r <= diff[DIV_W-1:0];
        q_r   <= {q_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[DIV_W-1:0];
        q_r   <= {q_r[DVD_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = q_r;
  assign done     = done_r;

endmodule

@@ rtl/core/trpm_ctrl.sv @@
`timescale 1ns / 1ps

module trpm_ctrl
  import trpm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  input  logic    in_tuser,
  output logic    in_tready,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = DOP_NONE;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_tuser == CMD_EVAL) begin
            cmd.op    = DOP_EVAL;
            state_nxt = ST_TAU;
          end else begin
            cmd.op = DOP_PULSE;
          end
        end
      end
      ST_TAU: begin
        if (sts.delta_zero) begin
          cmd.op    = DOP_ZERO;
          state_nxt = ST_SPK_D;
        end else begin
          cmd.op    = DOP_DIV_TAU;
          state_nxt = ST_TAU_W;
        end
      end
      ST_TAU_W: begin
        if (sts.div_done) begin
          cmd.op    = DOP_TAU_SAVE;
          state_nxt = ST_FDIV;
        end
      end
      ST_FDIV: begin
        cmd.op    = DOP_DIV_FRESH;
        state_nxt = ST_FDIV_W;
      end
      ST_FDIV_W: begin
        if (sts.div_done) begin
          cmd.op    = DOP_FRESH_SAVE;
          state_nxt = ST_SDIV;
        end
      end
      ST_SDIV: begin
        cmd.op    = DOP_DIV_SUM;
        state_nxt = ST_SDIV_W;
      end
      ST_SDIV_W: begin
        if (sts.div_done) begin
          cmd.op    = DOP_SAT;
          state_nxt = ST_SPK_D;
        end
      end
      ST_SPK_D: begin
        cmd.op    = DOP_SPK_DIFF;
        state_nxt = ST_SPK_C;
      end
      ST_SPK_C: begin
        cmd.op    = DOP_SPK_CMP;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        // Waits until the output register is free or being drained.
        if (sts.out_free) begin
          cmd.op    = DOP_EMIT;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/trpm_dp.sv @@
`timescale 1ns / 1ps

module trpm_dp
  import trpm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  dp_cmd_t                cmd,
  output dp_sts_t                sts,
  input  logic [TIME_W-1:0]      in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [RPM_BITS-1:0]   RPM_MAX   = '1;

  // Configuration and architectural state.
  logic [CFG_W-1:0]      filter_ms_r;
  logic [CFG_W-1:0]      spike_thr_r;
  logic [COUNT_BITS-1:0] count_r;
  logic [TIME_W-1:0]     latest_r;
  logic [TIME_W-1:0]     prev_r;
  logic [RPM_BITS-1:0]   h0_r;
  logic [RPM_BITS-1:0]   h1_r;
  logic [RPM_BITS-1:0]   h2_r;
  logic                  out_valid_r;

  // Working registers of one evaluation.
  logic [TIME_W-1:0]     delta_r;
  logic [FRESH_W-1:0]    fresh_prod_r;
  logic [CFG_W-1:0]      tau_r;
  logic [FRESH_W-1:0]    fresh_r;
  logic [PROD_W-1:0]     prod_r;
  logic                  rev_r;
  logic [RPM_BITS-1:0]   old_r;
  logic [RPM_BITS-1:0]   new_r;
  logic [RPM_BITS-1:0]   out_data_r;

  logic                  div_start;
  logic [DVD_W-1:0]      div_dividend;
  logic [DIV_W-1:0]      div_divisor;
  logic [DCNT_W-1:0]     div_nbits;
  logic [DVD_W-1:0]      div_quo;
  logic                  div_done;

  logic [FRESH_W-1:0]    fresh_prod_w;
  logic [PROD_W-1:0]     prod_w;
  logic [RPM_BITS-1:0]   sat_w;
  logic                  spike_w;
  logic [SPK_W-1:0]      new_lo_w;
  logic [SPK_W-1:0]      old_mid_w;
  logic [SPK_W-1:0]      new_hi_w;

  trpm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .nbits    (div_nbits),
    .quotient (div_quo),
    .done     (div_done)
  );

  // One shared serial divider serves all three divisions.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = DVD_W'(filter_ms_r);
    div_divisor  = delta_r;
    div_nbits    = DCNT_W'(CFG_W);
    case (cmd.op)
      DOP_DIV_TAU: begin
        div_start = 1'b1;
      end
      DOP_DIV_FRESH: begin
        div_start    = 1'b1;
        div_dividend = DVD_W'(fresh_prod_r);
        div_nbits    = DCNT_W'(FRESH_W);
      end
      DOP_DIV_SUM: begin
        div_start    = 1'b1;
        div_dividend = DVD_W'(prod_r) + DVD_W'(fresh_r);
        div_divisor  = DIV_W'(tau_r) + DIV_W'(1);
        div_nbits    = DCNT_W'(SUM_W);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  assign fresh_prod_w = FRESH_W'(count_r) * FRESH_W'(MS_PER_MIN);
  assign prod_w       = PROD_W'(h0_r) * PROD_W'(tau_r);
  assign sat_w        = (|div_quo[DVD_W-1:RPM_BITS]) ? RPM_MAX : div_quo[RPM_BITS-1:0];

  assign new_lo_w  = SPK_W'(new_r) * SPK_W'(SPK_LO_MUL);
  assign old_mid_w = SPK_W'(old_r) * SPK_W'(SPK_MID_MUL);
  assign new_hi_w  = SPK_W'(new_r) * SPK_W'(SPK_HI_MUL);
  assign spike_w   = rev_r && (CMP_W'(old_r) > CMP_W'(spike_thr_r)) &&
                     (new_lo_w < old_mid_w) && (new_hi_w > old_mid_w);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_ms_r <= '0;
      spike_thr_r <= SPIKE_THR_RST;
      count_r     <= '0;
      latest_r    <= '0;
      prev_r      <= '0;
      h0_r        <= '0;
      h1_r        <= '0;
      h2_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_FILTER_MS: filter_ms_r <= cfg_data;
          REG_SPIKE_THR: spike_thr_r <= cfg_data;
          default:       filter_ms_r <= filter_ms_r;
        endcase
      end
      if (cmd.op == DOP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        DOP_PULSE: begin
          latest_r <= in_tdata;
          if (count_r != COUNT_MAX) begin
            count_r <= count_r + COUNT_BITS'(1);
          end
        end
        DOP_EVAL: begin
          prev_r  <= latest_r;
          count_r <= '0;
        end
        DOP_ZERO: begin
          h0_r <= '0;
        end
        DOP_SAT: begin
          h0_r <= sat_w;
        end
        DOP_SPK_CMP: begin
          // A lone reversal of similar size on both sides, after a step above spike_thr_r, is a spike.
          if (spike_w) begin
            h1_r <= h0_r;
          end
        end
        DOP_EMIT: begin
          h2_r <= h1_r;
          h1_r <= h0_r;
        end
        default: begin
          h0_r <= h0_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DOP_EVAL: begin
        delta_r      <= latest_r - prev_r;
        fresh_prod_r <= fresh_prod_w;
      end
      DOP_TAU_SAVE: begin
        tau_r <= div_quo[CFG_W-1:0];
      end
      DOP_FRESH_SAVE: begin
        fresh_r <= div_quo[FRESH_W-1:0];
        prod_r  <= prod_w;
      end
      DOP_SPK_DIFF: begin
        rev_r <= ((h0_r > h1_r) && (h1_r < h2_r)) || ((h0_r < h1_r) && (h1_r > h2_r));
        old_r <= (h2_r > h1_r) ? (h2_r - h1_r) : (h1_r - h2_r);
        new_r <= (h1_r > h0_r) ? (h1_r - h0_r) : (h0_r - h1_r);
      end
      DOP_EMIT: begin
        out_data_r <= h2_r;
      end
      default: begin
        rev_r <= rev_r;
      end
    endcase
  end

  assign sts.delta_zero = (delta_r == '0);
  assign sts.div_done   = div_done;
  assign sts.out_free   = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_data_r);

endmodule

@@ rtl/core/tachometer_rpm_filter_unit.sv @@
`timescale 1ns / 1ps
// A pulse item is handled in the idle state; the next item may follow in the next cycle.
// An evaluate item uses one shared bit-serial divider three times (CFG_W, FRESH_W and
// SUM_W steps) unless the time delta is zero, which skips the divisions; the result waits
// while the output register is still full, and the next item is taken once it is emitted.
// Synchronous active-low reset clears the counter, timestamps, history and output
// valid, sets filter_ms to 0 and spike_threshold to 20; no clearing pass is needed.

module tachometer_rpm_filter_unit
  import trpm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [TIME_W-1:0]      in_tdata,   // [31:0] now_ms
  input  logic                   in_tuser,   // [0] command
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [19:0] rpm_value, upper bits zero
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  trpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  trpm_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

endmodule
